/* rtl/tpq_pkg.sv */
`timescale 1ns / 1ps

package tpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;
    localparam int PRIO_W          = 16;

    typedef logic signed [PRIO_W-1:0] t_prio;

    localparam t_prio PRIO_MAX = t_prio'(32767);

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_POP      = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_FAVOR    = 3'd3,
        CMD_AGE      = 3'd4,
        CMD_CONTAINS = 3'd5
    } t_cmd_code;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP,
        OP_REMOVE,
        OP_FAVOR,
        OP_AGE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [7:0]        thread_id;
        logic signed [7:0] priority_req;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         found_id;
        logic signed [15:0] found_priority;
        logic               present;
        logic [4:0]         entry_count_out;
        logic signed [15:0] head_priority;
    } t_result_word;

    // Broadcast to every cell: what to do this cycle and the priority of the new entry.
    typedef struct packed {
        t_cell_op op;
        t_prio    key_prio;
    } t_cell_ctl;

    function automatic t_prio sat_inc(input t_prio p);
        sat_inc = (p >= PRIO_MAX) ? PRIO_MAX : t_prio'(p + t_prio'(1));
    endfunction

endpackage

/* rtl/thread_priority_queue.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Word
// command   in         start & !busy                 i_cmd (t_cmd_word)
// result    out        o_done, one cycle, no stall   o_result (t_result_word)
// config    in         i_cfg_we                      i_cfg_wdata (top_priority)
//
// A command is handled in ST_IDLE and ST_EXEC: the accept edge latches the word,
// the edge that ends ST_EXEC runs the whole row of cells at once and registers
// the result; busy is high in ST_EXEC. o_done shows the result in the cycle after,
// while a new command may already be accepted. Reset (synchronous, active low) empties the queue at
// once. The receiver cannot stall; each result is shown for one cycle only.

module thread_priority_queue import tpq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd_word         i_cmd,
    output logic              o_done,
    output t_result_word      o_result,
    input  logic              i_cfg_we,
    input  logic signed [7:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_state             r_state;
    t_state             n_state;
    logic               exec_en;
    logic [2:0]         r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic signed [7:0]  r_req;
    logic signed [7:0]  r_top_priority;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_result_word       r_result;
    t_result_word       n_result;
    logic               r_done;
    t_cell_ctl          ctl;
    t_prio              head_after;
    t_prio              favor_prio;
    logic               found;
    logic               full;
    logic               empty;

    logic [ID_BITS-1:0]     cell_id [QUEUE_DEPTH];
    t_prio                  cell_prio [QUEUE_DEPTH];
    t_prio                  cell_next_prio [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_ge;
    logic [QUEUE_DEPTH-1:0] cell_seen;

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = start ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                busy    = 1'b0;
                exec_en = 1'b0;
            end
            ST_EXEC: begin
                busy    = 1'b1;
                exec_en = 1'b1;
            end
            default: begin
                busy    = 1'b0;
                exec_en = 1'b0;
            end
        endcase
    end

    assign found = cell_seen[QUEUE_DEPTH-1];
    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);

    // head once the favored entry is pulled out
    assign head_after = cell_seen[0] ? cell_prio[1] : cell_prio[0];
    assign favor_prio = sat_inc((r_count > CNT_W'(1)) ? head_after : t_prio'(r_top_priority));

    always_comb begin
        ctl.op       = OP_HOLD;
        ctl.key_prio = (r_cmd == CMD_FAVOR) ? favor_prio : t_prio'(r_req);
        n_count      = r_count;
        n_result     = '0;
        n_result.status = STS_OK;
        if (exec_en) begin
            case (r_cmd)
                CMD_INSERT: begin
                    if (full) begin
                        n_result.status = STS_FULL;
                    end else begin
                        ctl.op  = OP_INSERT;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_POP: begin
                    if (empty) begin
                        n_result.status = STS_EMPTY;
                    end else begin
                        ctl.op                  = OP_POP;
                        n_count                 = r_count - CNT_W'(1);
                        n_result.found_id       = 8'(cell_id[0]);
                        n_result.found_priority = cell_prio[0];
                    end
                end
                CMD_REMOVE: begin
                    if (empty) begin
                        n_result.status = STS_EMPTY;
                    end else if (!found) begin
                        n_result.status = STS_NOT_FOUND;
                    end else begin
                        ctl.op  = OP_REMOVE;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                CMD_FAVOR: begin
                    if (empty) begin
                        n_result.status = STS_EMPTY;
                    end else if (!found) begin
                        n_result.status = STS_NOT_FOUND;
                    end else begin
                        n_result.present = 1'b1;
                        if (r_count > CNT_W'(1)) begin
                            ctl.op = OP_FAVOR;
                        end
                    end
                end
                CMD_AGE: begin
                    ctl.op = OP_AGE;
                end
                CMD_CONTAINS: begin
                    n_result.present = found;
                end
                default: begin
                end
            endcase
        end
        n_result.entry_count_out = 5'(n_count);
        n_result.head_priority   = (n_count != '0) ? cell_next_prio[0] : '0;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] left_id;
        t_prio              left_prio;
        logic               left_valid;
        logic               left_ge;
        logic               seen_in;
        logic [ID_BITS-1:0] right_id;
        t_prio              right_prio;
        logic               right_valid;

        // the head's left neighbor is the new word itself
        if (g == 0) begin : g_head
            assign left_id    = r_id;
            assign left_prio  = ctl.key_prio;
            assign left_valid = 1'b1;
            assign left_ge    = 1'b1;
            assign seen_in    = 1'b0;
        end else begin : g_body
            assign left_id    = cell_id[g-1];
            assign left_prio  = cell_prio[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_ge    = cell_ge[g-1];
            assign seen_in    = cell_seen[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_id    = '0;
            assign right_prio  = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_id    = cell_id[g+1];
            assign right_prio  = cell_prio[g+1];
            assign right_valid = cell_valid[g+1];
        end

        tpq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_key_id      (r_id),
            .i_left_id     (left_id),
            .i_left_prio   (left_prio),
            .i_left_valid  (left_valid),
            .i_left_ge     (left_ge),
            .i_right_id    (right_id),
            .i_right_prio  (right_prio),
            .i_right_valid (right_valid),
            .i_seen        (seen_in),
            .o_id          (cell_id[g]),
            .o_prio        (cell_prio[g]),
            .o_next_prio   (cell_next_prio[g]),
            .o_valid       (cell_valid[g]),
            .o_ge          (cell_ge[g]),
            .o_seen        (cell_seen[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_done         <= 1'b0;
            r_top_priority <= 8'sd5;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= exec_en;
            if (i_cfg_we) begin
                r_top_priority <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd.cmd;
            r_id  <= ID_BITS'(i_cmd.thread_id);
            r_req <= i_cmd.priority_req;
        end
        if (exec_en) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/tpq_cell.sv */
`timescale 1ns / 1ps

module tpq_cell import tpq_pkg::*; #(
    parameter int ID_BITS = DEF_ID_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [ID_BITS-1:0] i_key_id,
    input  logic [ID_BITS-1:0] i_left_id,
    input  t_prio              i_left_prio,
    input  logic               i_left_valid,
    input  logic               i_left_ge,
    input  logic [ID_BITS-1:0] i_right_id,
    input  t_prio              i_right_prio,
    input  logic               i_right_valid,
    input  logic               i_seen,
    output logic [ID_BITS-1:0] o_id,
    output t_prio              o_prio,
    output t_prio              o_next_prio,
    output logic               o_valid,
    output logic               o_ge,
    output logic               o_seen
);

    logic [ID_BITS-1:0] r_id;
    t_prio              r_prio;
    logic               r_valid;
    logic [ID_BITS-1:0] n_id;
    t_prio              n_prio;
    logic               n_valid;
    logic               match;

    assign match  = r_valid && (r_id == i_key_id);
    assign o_ge   = r_valid && (r_prio >= i_ctl.key_prio);
    assign o_seen = i_seen | match;

    always_comb begin
        n_id    = r_id;
        n_prio  = r_prio;
        n_valid = r_valid;
        unique case (i_ctl.op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                // entries at or above the new priority stay; the first one below takes the new word
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_id   = i_key_id;
                        n_prio = i_ctl.key_prio;
                    end else begin
                        n_id   = i_left_id;
                        n_prio = i_left_prio;
                    end
                end
                n_valid = i_left_valid;
            end
            OP_POP: begin
                n_id    = i_right_id;
                n_prio  = i_right_prio;
                n_valid = i_right_valid;
            end
            OP_REMOVE: begin
                // close the gap from the first match toward the tail
                if (o_seen) begin
                    n_id    = i_right_id;
                    n_prio  = i_right_prio;
                    n_valid = i_right_valid;
                end
            end
            OP_FAVOR: begin
                // shift right up to and including the first match
                if (!i_seen) begin
                    n_id   = i_left_id;
                    n_prio = i_left_prio;
                end
            end
            OP_AGE: begin
                n_prio = sat_inc(r_prio);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_id        = r_id;
    assign o_prio      = r_prio;
    assign o_next_prio = n_prio;
    assign o_valid     = r_valid;

endmodule
